/* src/motion_threshold_layer_gate_macros.svh */
// Assertion macros for the checker file of the layer gate.
`ifndef MOTION_THRESHOLD_LAYER_GATE_MACROS_SVH
`define MOTION_THRESHOLD_LAYER_GATE_MACROS_SVH

// Generic form with an explicit clock and an active-low reset.
`define MTLG_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Short form for checkers that have clk and arst_n in scope.
`define MTLG_ASSERT(lbl, prop, msg) \
	`MTLG_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

/* src/mtlg_pkg.sv */
`timescale 1ns / 1ps

package mtlg_pkg;

	localparam int TIME_BITS         = 32;
	localparam int ACC_BITS          = 24;
	localparam int LAYER_BITS        = 5;
	localparam int LAYER_COUNT       = 32;
	localparam int MOVE_BITS         = 16;
	localparam int MAG_BITS          = MOVE_BITS + 1;
	localparam int POS_BITS          = 6;
	localparam int MS16_BITS         = 16;
	localparam int IDLE_BITS         = 15;
	localparam int ACC_RESET_DEFAULT = 200;

	localparam int APB_DATA_BITS = 64;
	localparam int APB_ADDR_BITS = 6;
	localparam int REG_IDX_BITS  = 3;

	// Register indexes; each register sits at byte address 8 * index.
	localparam logic [REG_IDX_BITS-1:0] REG_LAYER_SEL     = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_MOVE_THRESH   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_HOLD_TIMEOUT  = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_ACCUM_RESET   = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_PRIOR_IDLE    = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_EXCLUDED_MASK = 3'd5;

	typedef enum logic [2:0] {
		MODE_MOVE         = 3'd0,
		MODE_POS_PRESS    = 3'd1,
		MODE_KEY_PRESS    = 3'd2,
		MODE_LAYER_REPORT = 3'd3,
		MODE_TICK         = 3'd4
	} mode_t;

	typedef logic [TIME_BITS-1:0] tstamp_t;
	typedef logic [ACC_BITS-1:0]  acc_t;

	typedef struct packed {
		logic [2:0]                  mode;
		tstamp_t                     time_ms;
		logic signed [MOVE_BITS-1:0] move_value;
		logic [POS_BITS-1:0]         key_position;
		logic                        layer_still_on;
	} req_t;

	typedef struct packed {
		logic [LAYER_BITS-1:0] layer_number;
		logic                  layer_on;
		logic                  turn_on;
		logic                  turn_off;
		acc_t                  movement_total;
	} rsp_t;

	typedef struct packed {
		logic [LAYER_BITS-1:0] layer_sel;
		acc_t                  move_threshold;
		logic [MS16_BITS-1:0]  hold_timeout_ms;
		logic [MS16_BITS-1:0]  accum_reset_ms;
		logic [IDLE_BITS-1:0]  prior_idle_ms;
	} cfg_t;

endpackage

/* src/mtlg_regs.sv */
`timescale 1ns / 1ps

module mtlg_regs import mtlg_pkg::*; #(
	parameter int KEY_POSITIONS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output cfg_t                     cfg,
	output logic [KEY_POSITIONS-1:0] excluded_mask
);

	cfg_t                     cfg_q;
	logic [KEY_POSITIONS-1:0] mask_q;
	logic [REG_IDX_BITS-1:0]  idx;
	logic                     wr_en;

	assign idx   = paddr[APB_ADDR_BITS-1:3];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layer_sel       <= '0;
			cfg_q.move_threshold  <= '0;
			cfg_q.hold_timeout_ms <= '0;
			cfg_q.accum_reset_ms  <= MS16_BITS'(ACC_RESET_DEFAULT);
			cfg_q.prior_idle_ms   <= '0;
			mask_q                <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_LAYER_SEL:     cfg_q.layer_sel       <= pwdata[LAYER_BITS-1:0];
				REG_MOVE_THRESH:   cfg_q.move_threshold  <= pwdata[ACC_BITS-1:0];
				REG_HOLD_TIMEOUT:  cfg_q.hold_timeout_ms <= pwdata[MS16_BITS-1:0];
				REG_ACCUM_RESET:   cfg_q.accum_reset_ms  <= pwdata[MS16_BITS-1:0];
				REG_PRIOR_IDLE:    cfg_q.prior_idle_ms   <= pwdata[IDLE_BITS-1:0];
				REG_EXCLUDED_MASK: mask_q                <= pwdata[KEY_POSITIONS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LAYER_SEL:     prdata = APB_DATA_BITS'(cfg_q.layer_sel);
			REG_MOVE_THRESH:   prdata = APB_DATA_BITS'(cfg_q.move_threshold);
			REG_HOLD_TIMEOUT:  prdata = APB_DATA_BITS'(cfg_q.hold_timeout_ms);
			REG_ACCUM_RESET:   prdata = APB_DATA_BITS'(cfg_q.accum_reset_ms);
			REG_PRIOR_IDLE:    prdata = APB_DATA_BITS'(cfg_q.prior_idle_ms);
			REG_EXCLUDED_MASK: prdata = APB_DATA_BITS'(mask_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg           = cfg_q;
	assign excluded_mask = mask_q;

endmodule

/* src/motion_threshold_layer_gate.sv */
`timescale 1ns / 1ps
// Motion-threshold layer gate.
// Requests arrive on req (valid/ready) as timestamped events: movement, key
// position press, key code press, outside layer report and tick. Every request
// produces exactly one response on rsp (valid/ready) with the layer number, the
// layer state after the event, switch-on/switch-off flags and the movement total.
// Configuration is written over the APB-style port (64-bit data, register i at
// byte address 8*i, pready tied high); the user must write it only while no
// request is in flight, as the block does not enforce this. An accepted request
// is held in the request register, evaluated, and its response registered.
// Throughput: one request per cycle if not stalled; evaluation is a single stage of
// adders and comparators between the request register and the response register.
// When rsp_ready is low the response register holds, the request register fills
// behind it, and req_ready then falls until the response is taken; nothing is lost.
// Reset clears all event state and loads the register defaults (accumulator reset
// gap of 200 ms, everything else zero); no request is pending after reset.

module motion_threshold_layer_gate import mtlg_pkg::*; #(
	parameter int KEY_POSITIONS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  req_t                     req,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output rsp_t                     rsp,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	cfg_t                     cfg;
	logic [KEY_POSITIONS-1:0] excluded_mask;

	req_t    req_s1;
	logic    vld_s1;
	rsp_t    rsp_s2;
	logic    vld_s2;
	logic    fire;

	logic    active_q, reached_q, armed_q;
	acc_t    acc_q;
	tstamp_t last_key_q, last_move_q, deadline_q;

	logic    active_n, reached_n, armed_n;
	acc_t    acc_n;
	tstamp_t last_key_n, last_move_n, deadline_n;
	rsp_t    rsp_n;

	tstamp_t               now, d_move, d_key, d_hold;
	logic                  gap_clear, blocked, thr_zero, may_on, act, lay_ok;
	logic                  turn_on, turn_off, excl;
	acc_t                  acc_base, acc_sum;
	logic                  reached_base;
	logic [MAG_BITS-1:0]   mag;
	logic [ACC_BITS:0]     sum;
	logic [63:0]           mask_full;

	mtlg_regs #(
		.KEY_POSITIONS(KEY_POSITIONS)
	) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.cfg           (cfg),
		.excluded_mask (excluded_mask)
	);

	assign pready    = 1'b1;
	assign fire      = vld_s1 && (!vld_s2 || rsp_ready);
	assign req_ready = !vld_s1 || fire;
	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

	always_comb begin
		now       = req_s1.time_ms;
		d_move    = now - last_move_q;
		d_key     = now - last_key_q;
		d_hold    = now - deadline_q;
		lay_ok    = {4'd0, cfg.layer_sel} < 9'(LAYER_COUNT);
		mask_full = 64'(excluded_mask);

		// A movement gap longer than the reset window starts accumulation afresh.
		gap_clear    = !d_move[TIME_BITS-1] && (d_move > TIME_BITS'(cfg.accum_reset_ms));
		acc_base     = gap_clear ? '0 : acc_q;
		reached_base = gap_clear ? 1'b0 : reached_q;

		if (req_s1.move_value[MOVE_BITS-1]) begin
			mag = MAG_BITS'(17'h10000) - {1'b0, req_s1.move_value};
		end else begin
			mag = {1'b0, req_s1.move_value};
		end
		sum     = {1'b0, acc_base} + (ACC_BITS+1)'(mag);
		acc_sum = sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];

		blocked  = d_key[TIME_BITS-1] || (d_key < TIME_BITS'(cfg.prior_idle_ms));
		thr_zero = (cfg.move_threshold == '0);
		may_on   = !active_q && !blocked;
		act      = may_on && (thr_zero || reached_base || (acc_sum >= cfg.move_threshold));
		excl     = mask_full[req_s1.key_position];

		active_n    = active_q;
		reached_n   = reached_q;
		armed_n     = armed_q;
		acc_n       = acc_q;
		last_key_n  = last_key_q;
		last_move_n = last_move_q;
		deadline_n  = deadline_q;
		turn_on     = 1'b0;
		turn_off    = 1'b0;

		case (req_s1.mode)
			MODE_MOVE: begin
				if (lay_ok) begin
					acc_n       = acc_sum;
					reached_n   = reached_base ||
					              (may_on && !thr_zero && (acc_sum >= cfg.move_threshold));
					last_move_n = now;
					if ((cfg.hold_timeout_ms != '0) && (active_q || act)) begin
						deadline_n = now + TIME_BITS'(cfg.hold_timeout_ms);
						armed_n    = 1'b1;
					end
					active_n = active_q || act;
					turn_on  = act;
				end
			end
			MODE_POS_PRESS: begin
				if (active_q && (mask_full != '0) && !excl) begin
					active_n  = 1'b0;
					reached_n = 1'b0;
					acc_n     = '0;
					turn_off  = 1'b1;
				end
			end
			MODE_KEY_PRESS: begin
				last_key_n = now;
			end
			MODE_LAYER_REPORT: begin
				if (!req_s1.layer_still_on) begin
					active_n  = 1'b0;
					reached_n = 1'b0;
					acc_n     = '0;
					armed_n   = 1'b0;
				end
			end
			MODE_TICK: begin
				if (armed_q && !d_hold[TIME_BITS-1]) begin
					armed_n = 1'b0;
					if (active_q) begin
						active_n  = 1'b0;
						reached_n = 1'b0;
						acc_n     = '0;
						turn_off  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		rsp_n.layer_number   = cfg.layer_sel;
		rsp_n.layer_on       = active_n;
		rsp_n.turn_on        = turn_on;
		rsp_n.turn_off       = turn_off;
		rsp_n.movement_total = acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			active_q    <= 1'b0;
			reached_q   <= 1'b0;
			armed_q     <= 1'b0;
			acc_q       <= '0;
			last_key_q  <= '0;
			last_move_q <= '0;
			deadline_q  <= '0;
		end else begin
			vld_s1 <= (req_valid && req_ready) || (vld_s1 && !fire);
			vld_s2 <= fire || (vld_s2 && !rsp_ready);
			if (fire) begin
				active_q    <= active_n;
				reached_q   <= reached_n;
				armed_q     <= armed_n;
				acc_q       <= acc_n;
				last_key_q  <= last_key_n;
				last_move_q <= last_move_n;
				deadline_q  <= deadline_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_s2 <= rsp_n;
		end
	end

endmodule

/* src/mtlg_checker.sv */
`timescale 1ns / 1ps
`include "motion_threshold_layer_gate_macros.svh"

module mtlg_checker import mtlg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A single event never both switches the layer on and off.
	`MTLG_ASSERT(a_on_off_excl, rsp_valid |-> !(rsp.turn_on && rsp.turn_off), "turn_on and turn_off together")

	// A switch-on leaves the layer reported as on.
	`MTLG_ASSERT(a_on_state, (rsp_valid && rsp.turn_on) |-> rsp.layer_on, "turn_on with layer off")

	// A switch-off leaves the layer off and the accumulator empty.
	`MTLG_ASSERT(a_off_clear, (rsp_valid && rsp.turn_off) |-> (!rsp.layer_on && (rsp.movement_total == '0)), "turn_off without clearing")

	// A stalled response holds until it is taken.
	`MTLG_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)), "response changed while stalled")

endmodule

bind motion_threshold_layer_gate mtlg_checker u_checker (.*);
